### hdl/c2s_pkg.sv
// Package for the cartesian to spherical converter: widths, constants and the arctangent table.
package c2s_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AngleBitsDef    = 16;
  localparam int unsigned Guard           = 16;
  // Datapath width: 32-bit coordinate, 16 guard bits, CORDIC growth and sign.
  localparam int unsigned DW              = 52;
  localparam logic [31:0] GainInv         = 32'h9B74EDA8;

  localparam int unsigned RegMode  = 0;
  localparam int unsigned RegLimit = 1;

  typedef logic signed [DW-1:0] dp_t;

  // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### hdl/c2s_cell.sv
// One CORDIC vectoring micro-rotation cell with a register stage.
module c2s_cell #(
  parameter int unsigned Shift     = 0,
  parameter int unsigned AngleBits = c2s_pkg::AngleBitsDef,
  parameter int unsigned SideW     = 1
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  c2s_pkg::dp_t                   a_i,
  input  c2s_pkg::dp_t                   b_i,
  input  logic signed [AngleBits+1:0]    ang_i,
  input  logic [SideW-1:0]               side_i,
  output c2s_pkg::dp_t                   a_o,
  output c2s_pkg::dp_t                   b_o,
  output logic signed [AngleBits+1:0]    ang_o,
  output logic [SideW-1:0]               side_o
);
  import c2s_pkg::*;

  localparam logic [31:0] StepFull = atan_turn32(5'(Shift));
  localparam logic [AngleBits+1:0] Step = (AngleBits+2)'(StepFull >> (32 - AngleBits));

  dp_t a_q, b_q, a_d, b_d;
  logic signed [AngleBits+1:0] ang_q, ang_d;
  logic [SideW-1:0] side_q;

  always_comb begin
    if (!b_i[DW-1]) begin
      a_d   = a_i + (b_i >>> Shift);
      b_d   = b_i - (a_i >>> Shift);
      ang_d = ang_i + $signed(Step);
    end else begin
      a_d   = a_i - (b_i >>> Shift);
      b_d   = b_i + (a_i >>> Shift);
      ang_d = ang_i - $signed(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      ang_q  <= ang_d;
      side_q <= side_i;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign ang_o = ang_q;
  assign side_o = side_q;
endmodule

### hdl/c2s_gain.sv
// Gain removal stage: magnitude times the inverse CORDIC gain, truncating, registered.
module c2s_gain #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  c2s_pkg::dp_t     m_i,
  input  logic [SideW-1:0] side_i,
  output logic [47:0]      m_o,
  output logic [SideW-1:0] side_o
);
  import c2s_pkg::*;

  // Magnitude stays below 2^50, so hi is at most 18 bits.
  logic [DW-1:0] u;
  logic [19:0] hi;
  logic [31:0] lo;
  logic [51:0] phi_q;
  logic [63:0] plo_q;
  logic [SideW-1:0] side1_q, side2_q;
  logic [47:0] m_q;

  assign u  = m_i[DW-1] ? '0 : m_i;
  assign hi = u[DW-1:32];
  assign lo = u[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_q   <= {32'd0, hi} * {20'd0, GainInv};
      plo_q   <= {32'd0, lo} * {32'd0, GainInv};
      side1_q <= side_i;
      m_q     <= 48'(phi_q + {20'd0, plo_q[63:32]});
      side2_q <= side1_q;
    end
  end

  assign m_o = m_q;
  assign side_o = side2_q;
endmodule

### hdl/cartesian_to_spherical.sv
// Top level of the pipelined cartesian to spherical converter.
// This block turns a signed Q16.16 point (x, y, z) into a Q16.16 radius, an azimuth and a
// polar angle, both as 16-bit fractions of a full turn. It is a row of CORDIC cells: one
// input register, CORDIC_STAGES cells for atan2(y, x), a gain multiplier with a product register
// and a sum register, a prefold register, CORDIC_STAGES cells for atan2(rho, z), a second gain
// multiplier and a final output register. One word is accepted every cycle unless the master
// side stalls. The whole row advances only when the output register is free or being emptied,
// so a stall on the master side holds every stage. Configuration is sampled by the words as
// they flow past the stage that needs it, and must only change while the pipeline is empty.
module cartesian_to_spherical #(
  parameter int unsigned CORDIC_STAGES = c2s_pkg::CordicStagesDef,
  parameter int unsigned ANGLE_BITS    = c2s_pkg::AngleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // radius[31:0], azimuth[47:32], polar_angle[63:48]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import c2s_pkg::*;

  localparam int unsigned AW = ANGLE_BITS + 2;
  localparam int unsigned Lat = 2 * CORDIC_STAGES + 7;
  localparam logic signed [AW-1:0] Half    = AW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [AW-1:0] Quarter = AW'(1) <<< (ANGLE_BITS - 2);
  // Side band through pass one: az angle, y-is-zero, x-positive.
  localparam int unsigned S1W = AW + 2;

  logic mode_q;
  logic [15:0] limit_q;
  logic adv;
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(RegMode)) mode_q <= cfg_data_i[0];
      else limit_q <= cfg_data_i;
    end
  end

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[Lat-1];

  // Input fold into the right half plane.
  logic signed [31:0] xi, yi, zi;
  assign xi = s_axis_tdata[31:0];
  assign yi = s_axis_tdata[63:32];
  assign zi = s_axis_tdata[95:64];

  dp_t a0_q, b0_q;
  logic signed [AW-1:0] g0_q;
  logic [S1W+31:0] sb0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (xi < 0) begin
        a0_q <= -(DW'(xi) <<< Guard);
        b0_q <= -(DW'(yi) <<< Guard);
        g0_q <= Half;
      end else begin
        a0_q <= DW'(xi) <<< Guard;
        b0_q <= DW'(yi) <<< Guard;
        g0_q <= '0;
      end
      sb0_q <= {zi, (yi == 0), (xi > 0), AW'(0)};
    end
  end

  // First pass. Side band carries z, flags and the az accumulator slot unused here.
  dp_t a1 [CORDIC_STAGES+1];
  dp_t b1 [CORDIC_STAGES+1];
  logic signed [AW-1:0] g1 [CORDIC_STAGES+1];
  logic [S1W+31:0] s1 [CORDIC_STAGES+1];
  assign a1[0] = a0_q;
  assign b1[0] = b0_q;
  assign g1[0] = g0_q;
  assign s1[0] = sb0_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_p1
    c2s_cell #(.Shift(i), .AngleBits(ANGLE_BITS), .SideW(S1W+32)) u_cell (
      .clk_i, .en_i(adv), .a_i(a1[i]), .b_i(b1[i]), .ang_i(g1[i]), .side_i(s1[i]),
      .a_o(a1[i+1]), .b_o(b1[i+1]), .ang_o(g1[i+1]), .side_o(s1[i+1]));
  end

  logic [47:0] rho;
  logic [S1W+31:0] s1g;
  logic [S1W+31:0] s1in;
  assign s1in = {s1[CORDIC_STAGES][S1W+31:AW], g1[CORDIC_STAGES]};
  c2s_gain #(.SideW(S1W+32)) u_gain1 (
    .clk_i, .en_i(adv), .m_i(a1[CORDIC_STAGES]), .side_i(s1in), .m_o(rho), .side_o(s1g));

  // Fold for the polar pass; also finish the azimuth.
  logic signed [31:0] zg;
  logic signed [AW-1:0] azr;
  logic yzero, xpos;
  assign zg = s1g[S1W+31:S1W];
  assign yzero = s1g[AW+1];
  assign xpos = s1g[AW];
  assign azr = s1g[AW-1:0];

  logic [ANGLE_BITS-1:0] azw;
  logic [15:0] azo;
  always_comb begin
    if (yzero) azw = xpos ? '0 : ANGLE_BITS'(Half);
    else azw = azr[ANGLE_BITS-1:0];
    if (ANGLE_BITS > 16)
      azo = 16'((azw + (ANGLE_BITS'(1) << (ANGLE_BITS > 16 ? ANGLE_BITS - 17 : 0)))
                >> (ANGLE_BITS - 16));
    else
      azo = 16'(32'(azw) << (16 - ANGLE_BITS));
  end

  dp_t c0_q, d0_q;
  logic signed [AW-1:0] p0_q;
  logic [64:0] sp0_q;   // rho, az out, mode
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (mode_q && zg < 0) begin
        c0_q <= DW'(rho);
        d0_q <= -(DW'(zg) <<< Guard);
        p0_q <= Quarter;
      end else begin
        c0_q <= mode_q ? (DW'(zg) <<< Guard) : '0;
        d0_q <= DW'(rho);
        p0_q <= '0;
      end
      sp0_q <= {rho, azo, mode_q};
    end
  end

  dp_t a2 [CORDIC_STAGES+1];
  dp_t b2 [CORDIC_STAGES+1];
  logic signed [AW-1:0] g2 [CORDIC_STAGES+1];
  logic [64:0] s2 [CORDIC_STAGES+1];
  assign a2[0] = c0_q;
  assign b2[0] = d0_q;
  assign g2[0] = p0_q;
  assign s2[0] = sp0_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_p2
    c2s_cell #(.Shift(i), .AngleBits(ANGLE_BITS), .SideW(65)) u_cell (
      .clk_i, .en_i(adv), .a_i(a2[i]), .b_i(b2[i]), .ang_i(g2[i]), .side_i(s2[i]),
      .a_o(a2[i+1]), .b_o(b2[i+1]), .ang_o(g2[i+1]), .side_o(s2[i+1]));
  end

  logic [47:0] r3;
  logic [65+AW-1:0] s3, s3in;
  assign s3in = {s2[CORDIC_STAGES], g2[CORDIC_STAGES]};
  c2s_gain #(.SideW(65+AW)) u_gain2 (
    .clk_i, .en_i(adv), .m_i(a2[CORDIC_STAGES]), .side_i(s3in), .m_o(r3), .side_o(s3));

  // Output stage.
  logic [47:0] mag, radr;
  logic [31:0] rad;
  logic signed [AW-1:0] pol, polc;
  logic [15:0] polo;
  logic md;
  assign md = s3[AW];
  assign pol = s3[AW-1:0];
  always_comb begin
    mag = md ? r3 : s3[AW+65-1 -: 48];
    radr = (mag + 48'h8000) >> Guard;
    rad = (radr > 48'hFFFFFFFF) ? 32'hFFFFFFFF : radr[31:0];
    polc = pol;
    if (pol < 0) polc = '0;
    if (pol > Half) polc = Half;
    if (ANGLE_BITS > 16)
      polo = 16'((polc + (AW'(1) << (ANGLE_BITS > 16 ? ANGLE_BITS - 17 : 0)))
                 >>> (ANGLE_BITS - 16));
    else
      polo = 16'(polc <<< (16 - ANGLE_BITS));
    if (!md) polo = '0;
  end

  logic [63:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (rad <= {16'd0, limit_q}) out_q <= '0;
      else out_q <= {polo, s3[AW+16:AW+1], rad};
    end
  end
  assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow pipeline advance");
  a_polar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:48] <= 16'd32768)
    else $error("polar angle beyond half turn");
`endif
endmodule

### verif/c2s_checker.sv
// Checker for the cartesian to spherical converter: predicts each result and compares it.
module c2s_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [95:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import c2s_pkg::*;

  typedef struct packed {
    logic [15:0] polar;
    logic [15:0] azimuth;
    logic [31:0] radius;
  } sph_t;

  localparam int unsigned Stages = 16;

  // Arctangent of 2^-i in turns, 2^32 per turn.
  localparam logic [31:0] AtanTurn[16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic        mode_3d;
  logic [15:0] radius_floor;
  sph_t        expected_q[$];
  int          fails;
  int          checked;
  int          outstanding;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;
  assign checked_o    = checked;

  // Drives b toward zero and returns the angle turned, 65536 per turn.
  function automatic longint vector_turn(inout longint a, inout longint b);
    longint acc;
    longint ta;
    longint tb;
    acc = 0;
    for (int i = 0; i < Stages; i++) begin
      ta = a;
      tb = b;
      if (tb >= 0) begin
        a = ta + (tb >>> i);
        b = tb - (ta >>> i);
        acc += longint'(AtanTurn[i] >> 16);
      end else begin
        a = ta - (tb >>> i);
        b = tb + (ta >>> i);
        acc -= longint'(AtanTurn[i] >> 16);
      end
    end
    return acc;
  endfunction

  // Removes the CORDIC gain, truncating.
  function automatic longint remove_gain(longint m);
    logic [63:0] u;
    logic [63:0] lo_prod;
    u = (m < 0) ? 64'd0 : 64'(m);
    lo_prod = {32'd0, u[31:0]} * {32'd0, GainInv};
    return longint'({32'd0, u[63:32]} * {32'd0, GainInv} + (lo_prod >> 32));
  endfunction

  function automatic sph_t convert_point(logic [95:0] w);
    longint x;
    longint y;
    longint z;
    longint a;
    longint b;
    longint c;
    longint d;
    longint t;
    longint az;
    longint pol;
    longint mag;
    logic [63:0] rad;
    sph_t r;
    x = longint'($signed(w[31:0]));
    y = longint'($signed(w[63:32]));
    z = longint'($signed(w[95:64]));
    a = x <<< 16;
    b = y <<< 16;
    az = 0;
    pol = 0;
    if (a < 0) begin
      a = -a;
      b = -b;
      az = 32768;
    end
    az += vector_turn(a, b);
    mag = remove_gain(a);
    if (mode_3d) begin
      c = z <<< 16;
      d = mag;
      if (c < 0) begin
        t = c;
        c = d;
        d = -t;
        pol = 16384;
      end
      pol += vector_turn(c, d);
      mag = remove_gain(c);
      if (pol < 0) pol = 0;
      if (pol > 32768) pol = 32768;
    end
    rad = (64'(mag) + 64'd32768) >> 16;
    if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
    if (y == 0) az = (x > 0) ? 0 : 32768;
    r.radius  = rad[31:0];
    r.azimuth = az[15:0];
    r.polar   = pol[15:0];
    if (rad <= 64'(radius_floor)) r = '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sph_t got;
    sph_t want;
    if (!rst_ni) begin
      mode_3d      <= 1'b1;
      radius_floor <= '0;
      fails   = 0;
      checked = 0;
      expected_q.delete();
      outstanding = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(RegMode)) mode_3d <= cfg_data_i[0];
        else radius_floor <= cfg_data_i;
      end
      if (s_valid_i && s_ready_i) expected_q.push_back(convert_point(s_data_i));
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", got.radius, '0);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got.radius !== want.radius) report_mismatch("radius", got.radius, want.radius);
          if (got.azimuth !== want.azimuth)
            report_mismatch("azimuth", 32'(got.azimuth), 32'(want.azimuth));
          if (got.polar !== want.polar)
            report_mismatch("polar_angle", 32'(got.polar), 32'(want.polar));
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

### verif/tb_cartesian_to_spherical.sv
// Testbench top for the cartesian to spherical converter: stimulus, stalls and verdict.
module tb_cartesian_to_spherical;
  import c2s_pkg::*;

  // Pipeline depth of the block with the default stage count, plus some slack.
  localparam int Drain     = 2 * 16 + 7 + 10;
  localparam int IdleLimit = 3000;
  localparam int HoldLen   = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [95:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [63:0] m_data;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          checked;
  int          words_sent;
  int          idle_cycles;
  bit          sink_on;

  cartesian_to_spherical u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  c2s_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one word and holds it until the block takes it, then maybe idles.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit may_gap);
    int gap;
    s_valid <= 1'b1;
    s_data  <= {z, y, x};
    do @(posedge clk_i); while (!s_ready);
    words_sent++;
    gap = may_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Registers may only change with the pipeline empty, so drain first.
  task automatic write_reg(logic idx, logic [15:0] val);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random coordinate: full range, small magnitudes, zero, or a boundary value.
  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 75) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    if (r < 85) return '0;
    if (r < 90) return 32'($signed($urandom_range(0, 64)) - 32);
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic random_points(int count);
    repeat (count) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
  endtask

  // Receiver: random stalls, and once a long hold-off while the sender keeps pushing.
  initial begin
    int stall;
    bit held;
    m_ready = 1'b0;
    held = 1'b0;
    wait (sink_on);
    forever begin
      @(posedge clk_i);
      if (!held && words_sent >= 120) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    s_valid    = 1'b0;
    s_data     = '0;
    cfg_we     = 1'b0;
    cfg_idx    = 1'b0;
    cfg_data   = '0;
    words_sent = 0;
    sink_on    = 1'b0;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni  <= 1'b1;
    sink_on = 1'b1;

    // Directed points under the reset settings (3-D, no radius floor).
    send_point(32'h0, 32'h0, 32'h0, 1'b0);                       // origin
    send_point(32'h0001_0000, 32'h0, 32'h0, 1'b0);               // +x axis, zero y
    send_point(32'hFFFF_0000, 32'h0, 32'h0, 1'b0);               // -x axis, half turn
    send_point(32'h0, 32'h0, 32'h0001_0000, 1'b0);               // +z only
    send_point(32'h0, 32'h0, 32'hFFFF_0000, 1'b0);               // -z, polar half turn
    send_point(32'h0, 32'h0001_0000, 32'h0, 1'b0);               // +y axis
    send_point(32'h0, 32'hFFFF_0000, 32'h0, 1'b0);               // -y, negative azimuth wraps
    send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);       // azimuth just under a turn
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0); // large radius
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0); // most negative corner
    send_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);                       // x zero, y zero: half turn
    send_point(32'h1, 32'h1, 32'h1, 1'b0);                       // tiny radius
    send_point(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0003_0000, 32'h0004_0000, 32'hFFF4_0000, 1'b1);
    random_points(90);

    // Radius floor at its maximum: most small points collapse to zero.
    write_reg(1'(RegLimit), 16'hFFFF);
    send_point(32'h0, 32'h0000_FFFF, 32'h0, 1'b0);               // at the floor
    send_point(32'h0, 32'h0001_0000, 32'h0, 1'b0);               // just above
    random_points(90);

    // 2-D mode, no floor.
    write_reg(1'(RegMode), 16'h0);
    write_reg(1'(RegLimit), 16'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
    random_points(100);

    // 2-D mode with a floor of 300.
    write_reg(1'(RegLimit), 16'd300);
    random_points(100);

    // Back to 3-D with a small floor.
    write_reg(1'(RegMode), 16'h1);
    write_reg(1'(RegLimit), 16'd5);
    random_points(100);

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("covered %0d points over five register settings, %0d results compared",
             words_sent, checked);
    $display("both register extremes, 2-D and 3-D modes, and a long output hold-off were run");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
